FILE: hw/rtl/bnz_pkg.sv
// Package for the bitmap next-zero search: item types, microcode types and the control store.
`timescale 1ns / 1ps

package bnz_pkg;

    // Fixed field widths of the item channels.
    localparam int ADDR_W        = 10;
    localparam int DATA_W        = 64;
    localparam int INDEX_W       = 16;
    localparam int MAX_WORD_BITS = 64;

    // Default geometry of the bitmap.
    localparam int DEF_WORD_BITS = 64;
    localparam int DEF_WORDS     = 1024;

    // Item kinds.
    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_SEARCH = 1'b1;

    typedef struct packed {
        logic                 kind;
        logic [ADDR_W-1:0]    word_addr;
        logic [DATA_W-1:0]    word_data;
        logic [INDEX_W-1:0]   start_index;
    } t_in_item;

    typedef struct packed {
        logic [INDEX_W-1:0]   found_index;
        logic                 not_found;
    } t_out_item;

    // Datapath operation selected by one microinstruction.
    typedef enum logic [2:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_DIVIDE,
        OP_SPLIT,
        OP_SCAN,
        OP_ADVANCE,
        OP_HIT,
        OP_MISS
    } t_op;

    // Branch condition tested by the sequencer.
    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_SEARCH_TAKEN,
        COND_PAST_END,
        COND_HAS_CLEAR,
        COND_NEXT_PAST_END,
        COND_OUT_FREE
    } t_cond;

    typedef logic [2:0] t_step;

    localparam t_step STEP_IDLE    = 3'd0;
    localparam t_step STEP_DIVIDE  = 3'd1;
    localparam t_step STEP_SPLIT   = 3'd2;
    localparam t_step STEP_SCAN    = 3'd3;
    localparam t_step STEP_HIT     = 3'd4;
    localparam t_step STEP_ADVANCE = 3'd5;
    localparam t_step STEP_MISS    = 3'd6;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_step jump_step;
        t_step fall_step;
    } t_uword;

    // Status from the datapath that the branch conditions look at.
    typedef struct packed {
        logic search_taken;
        logic past_end;
        logic has_clear;
        logic next_past_end;
        logic out_free;
    } t_dp_flags;

    // Control store: one microinstruction per step.
    function automatic t_uword ucode_rom(input t_step step);
        t_uword w;
        unique case (step)
            STEP_IDLE:    w = '{OP_ACCEPT,  COND_SEARCH_TAKEN,  STEP_DIVIDE, STEP_IDLE};
            STEP_DIVIDE:  w = '{OP_DIVIDE,  COND_PAST_END,      STEP_MISS,   STEP_SPLIT};
            STEP_SPLIT:   w = '{OP_SPLIT,   COND_ALWAYS,        STEP_SCAN,   STEP_SCAN};
            STEP_SCAN:    w = '{OP_SCAN,    COND_HAS_CLEAR,     STEP_HIT,    STEP_ADVANCE};
            STEP_HIT:     w = '{OP_HIT,     COND_OUT_FREE,      STEP_IDLE,   STEP_HIT};
            STEP_ADVANCE: w = '{OP_ADVANCE, COND_NEXT_PAST_END, STEP_MISS,   STEP_SCAN};
            STEP_MISS:    w = '{OP_MISS,    COND_OUT_FREE,      STEP_IDLE,   STEP_MISS};
            default:      w = '{OP_NOP,     COND_ALWAYS,        STEP_IDLE,   STEP_IDLE};
        endcase
        return w;
    endfunction

    // Position of the lowest set bit; the caller never uses it for an all-zero word.
    function automatic logic [6:0] trailing_zeros(input logic [MAX_WORD_BITS-1:0] v);
        logic [6:0] n;
        n = 7'(MAX_WORD_BITS);
        for (int i = MAX_WORD_BITS - 1; i >= 0; i--) begin
            if (v[i]) begin
                n = 7'(i);
            end
        end
        return n;
    endfunction

endpackage

FILE: hw/rtl/bitmap_next_zero_search_top.sv
// Top level of the bitmap next-zero search: sequencer and datapath joined.
`timescale 1ns / 1ps

// This block holds a bitmap of WORDS words of WORD_BITS bits in a memory with one write port
// and one read port, and answers "first clear bit strictly after start_index" queries,
// flagging not_found when the scan runs past the end of the map or past bit 65535. A small
// microprogram in a read-only control store steps a plain datapath. A write beat gives no
// result. A search whose first word read holds a clear bit goes through accept, reciprocal
// multiply to get the word number, split into word and bit offset while the word is read,
// trailing-ones count and result; each full word that is skipped adds an advance and a scan
// step, since the memory read port delivers one word per advance/scan pair. A start on the
// last bit of the map or past it goes from divide straight to miss. The result sits in an
// output register, so the block returns to accepting beats while it waits to be taken;
// a search only stalls at its own result step if the previous result is still held there.
// Words never written since reset read as undefined, so a search must only cover written
// words. The memory needs no clearing pass after reset.

module bitmap_next_zero_search_top
    import bnz_pkg::*;
#(
    parameter int WORD_BITS = DEF_WORD_BITS,
    parameter int WORDS     = DEF_WORDS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    t_uword    w_uword;
    t_dp_flags w_flags;

    // The sequencer owns the step counter; every conditional branch tests one datapath flag.
    bnz_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_uword (w_uword)
    );

    // The datapath holds the bitmap, the index registers and the output register.
    bnz_datapath #(
        .WORD_BITS (WORD_BITS),
        .WORDS     (WORDS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_uword     (w_uword),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .o_flags     (w_flags)
    );

endmodule

FILE: hw/rtl/bnz_useq.sv
// Microcode sequencer of the bitmap next-zero search: step counter, control store and branches.
`timescale 1ns / 1ps

module bnz_useq
    import bnz_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_dp_flags i_flags,
    output t_uword    o_uword
);

    t_step  r_step;
    t_step  n_step;
    t_uword w_uword;
    logic   w_cond_true;

    assign w_uword = ucode_rom(r_step);
    assign o_uword = w_uword;

    always_comb begin
        unique case (w_uword.cond)
            COND_ALWAYS:        w_cond_true = 1'b1;
            COND_SEARCH_TAKEN:  w_cond_true = i_flags.search_taken;
            COND_PAST_END:      w_cond_true = i_flags.past_end;
            COND_HAS_CLEAR:     w_cond_true = i_flags.has_clear;
            COND_NEXT_PAST_END: w_cond_true = i_flags.next_past_end;
            COND_OUT_FREE:      w_cond_true = i_flags.out_free;
            default:            w_cond_true = 1'b1;
        endcase
    end

    always_comb begin
        n_step = w_cond_true ? w_uword.jump_step : w_uword.fall_step;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    // An accepted search always goes on to the divide step.
    a_search_enters_divide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == STEP_IDLE && i_flags.search_taken) |=> (r_step == STEP_DIVIDE))
        else $error("accepted search did not enter the divide step");

    // A word is scanned only after its read was issued in the step before.
    a_scan_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == STEP_SCAN) |->
            ($past(r_step) == STEP_SPLIT || $past(r_step) == STEP_ADVANCE))
        else $error("scan step entered without a preceding word read");

endmodule

FILE: hw/rtl/bnz_datapath.sv
// Datapath of the bitmap next-zero search: bitmap memory, index registers and output register.
`timescale 1ns / 1ps

module bnz_datapath
    import bnz_pkg::*;
#(
    parameter int WORD_BITS = DEF_WORD_BITS,
    parameter int WORDS     = DEF_WORDS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_uword    i_uword,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item,
    output t_dp_flags o_flags
);

    localparam int AW       = $clog2(WORDS);
    localparam int BW       = $clog2(WORD_BITS);
    localparam int IW       = INDEX_W + 1;
    localparam int TOTAL    = WORDS * WORD_BITS;
    localparam int LIMIT    = (TOTAL < (1 << INDEX_W)) ? TOTAL : (1 << INDEX_W);
    localparam int SHIFT    = 24;
    localparam int RECIP    = ((1 << SHIFT) + WORD_BITS - 1) / WORD_BITS;
    localparam int RW       = SHIFT - 2;
    localparam int PW       = IW + RW + 2;

    localparam logic [IW-1:0] LIMIT_V = IW'(LIMIT);
    localparam logic [IW-1:0] WB_V    = IW'(WORD_BITS);
    localparam logic [RW-1:0] RECIP_V = RW'(RECIP);

    logic [WORD_BITS-1:0] mem [WORDS];

    logic [IW-1:0]        r_idx;
    logic [IW-1:0]        r_q;
    logic [IW-1:0]        r_w;
    logic [IW-1:0]        r_base;
    logic [BW-1:0]        r_b;
    logic [BW-1:0]        r_tz;
    logic [WORD_BITS-1:0] r_rd;
    logic                 r_out_valid;
    t_out_item            r_out;

    logic                 w_take;
    logic                 w_wr_en;
    logic [IW-1:0]        w_wr_addr;
    logic [IW-1:0]        w_rd_w;
    logic [PW-1:0]        w_prod;
    logic [IW-1:0]        w_qbase;
    logic [WORD_BITS-1:0] w_clear;
    logic [IW-1:0]        w_next_base;
    logic [IW-1:0]        w_hit;
    logic                 w_out_free;
    logic                 w_load;
    t_out_item            n_out;

    assign o_in_stall  = (i_uword.op != OP_ACCEPT);
    assign w_take      = i_in_valid && !o_in_stall;
    assign w_wr_en     = w_take && (i_in_item.kind == KIND_WRITE)
                         && (32'(i_in_item.word_addr) < 32'(WORDS));
    assign w_wr_addr   = IW'(i_in_item.word_addr);

    // Quotient by the word width through a reciprocal; exact for every 17-bit index at the default width of 64.
    assign w_prod      = PW'(r_idx) * PW'(RECIP_V);
    assign w_qbase     = IW'(r_q * WB_V);
    assign w_clear     = (~r_rd) >> r_b;
    assign w_next_base = r_base + WB_V;
    assign w_hit       = r_idx + IW'(r_tz);
    assign w_rd_w      = (i_uword.op == OP_ADVANCE) ? (r_w + IW'(1)) : r_q;

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_load      = w_out_free && (i_uword.op == OP_HIT || i_uword.op == OP_MISS);

    always_comb begin
        o_flags.search_taken  = w_take && (i_in_item.kind == KIND_SEARCH);
        o_flags.past_end      = (r_idx >= LIMIT_V);
        o_flags.has_clear     = |w_clear;
        o_flags.next_past_end = (w_next_base >= LIMIT_V);
        o_flags.out_free      = w_out_free;
    end

    always_comb begin
        n_out.found_index = '0;
        n_out.not_found   = 1'b1;
        if (i_uword.op == OP_HIT && w_hit < LIMIT_V) begin
            n_out.found_index = w_hit[INDEX_W-1:0];
            n_out.not_found   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[w_wr_addr[AW-1:0]] <= i_in_item.word_data[WORD_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd <= mem[w_rd_w[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        unique case (i_uword.op)
            OP_ACCEPT: begin
                if (w_take) begin
                    r_idx <= IW'(i_in_item.start_index) + IW'(1);
                end
            end
            OP_DIVIDE: begin
                r_q <= IW'(w_prod >> SHIFT);
            end
            OP_SPLIT: begin
                r_w    <= r_q;
                r_base <= w_qbase;
                r_b    <= BW'(r_idx - w_qbase);
            end
            OP_SCAN: begin
                r_tz <= BW'(trailing_zeros(MAX_WORD_BITS'(w_clear)));
            end
            OP_ADVANCE: begin
                r_w    <= r_w + IW'(1);
                r_base <= w_next_base;
                r_idx  <= w_next_base;
                r_b    <= '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // In every scan step the word base and bit offset recombine to the current index.
    a_split_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_uword.op == OP_SCAN) |-> (IW'(r_base + IW'(r_b)) == r_idx))
        else $error("word base and bit offset do not match the index");

    // A new result appears only from a result step of the program.
    a_result_from_program: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(i_uword.op) == OP_HIT || $past(i_uword.op) == OP_MISS))
        else $error("result beat raised outside a result step");

endmodule

FILE: tb/bitmap_search_checker.sv
// Checker for the bitmap next-zero search: tracks the map, predicts answers, compares results.
`timescale 1ns / 1ps

module bitmap_search_checker
    import bnz_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_item  i_in_item,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_item i_out_item,
    output int        o_fail_count,
    output int        o_pending
);

    localparam int WORD_BITS = DEF_WORD_BITS;
    localparam int WORDS     = DEF_WORDS;
    localparam int AW        = $clog2(WORDS);
    localparam int MAP_BITS  = (WORDS * WORD_BITS < 65536) ? WORDS * WORD_BITS : 65536;

    logic [DATA_W-1:0] map_copy [WORDS];
    t_out_item         answers_due [$];
    t_out_item         due;
    int                fails;

    // First clear bit strictly after the start index, or not_found past the map end.
    function automatic t_out_item next_clear_after(input logic [INDEX_W-1:0] start);
        t_out_item         r;
        int unsigned       pos;
        int unsigned       w;
        logic [DATA_W-1:0] open_bits;
        r.found_index = '0;
        r.not_found   = 1'b1;
        pos = int'(start) + 1;
        while (pos < MAP_BITS) begin
            w = pos / WORD_BITS;
            open_bits = ~map_copy[w[AW-1:0]] >> (pos % WORD_BITS);
            for (int k = 0; k < WORD_BITS; k++) begin
                if (open_bits[k]) begin
                    if (pos + k < MAP_BITS) begin
                        r.found_index = INDEX_W'(pos + k);
                        r.not_found   = 1'b0;
                    end
                    return r;
                end
            end
            pos = (w + 1) * WORD_BITS;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            answers_due.delete();
            fails = 0;
            o_fail_count <= 0;
            o_pending    <= 0;
        end else begin
            // Results are matched before new searches are queued at the same edge.
            if (i_out_valid && !i_out_stall) begin
                if (answers_due.size() == 0) begin
                    $error("result beat with no search waiting: found_index %0d not_found %0d",
                           i_out_item.found_index, i_out_item.not_found);
                    fails++;
                end else begin
                    due = answers_due.pop_front();
                    if (i_out_item.found_index !== due.found_index) begin
                        $error("found_index: expected %0d, got %0d",
                               due.found_index, i_out_item.found_index);
                        fails++;
                    end
                    if (i_out_item.not_found !== due.not_found) begin
                        $error("not_found: expected %0d, got %0d",
                               due.not_found, i_out_item.not_found);
                        fails++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_in_item.kind == KIND_WRITE) begin
                    if (i_in_item.word_addr < WORDS) begin
                        map_copy[i_in_item.word_addr] = i_in_item.word_data;
                    end
                end else begin
                    answers_due.push_back(next_clear_after(i_in_item.start_index));
                end
            end
            o_fail_count <= fails;
            o_pending    <= answers_due.size();
        end
    end

endmodule

FILE: tb/testbench.sv
// Testbench top for the bitmap next-zero search: clock, reset, beat traffic and the verdict.
`timescale 1ns / 1ps

module testbench;
    import bnz_pkg::*;

    localparam int WORD_BITS     = DEF_WORD_BITS;
    localparam int WORDS         = DEF_WORDS;
    localparam int AW            = $clog2(WORDS);
    localparam int BIT_W         = $clog2(DATA_W);
    localparam int MAP_BITS      = (WORDS * WORD_BITS < 65536) ? WORDS * WORD_BITS : 65536;
    localparam int ITEM_TARGET   = 1650;
    localparam int CALM_TAIL     = 200;
    localparam int SHUFFLE_EVERY = 100;
    localparam int DRAIN_AT      = 500;
    localparam int HOLD_AT       = 900;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 20;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_stall;
    t_out_item out_item;
    int        fail_count;
    int        pending;

    // The sender keeps its own picture of which map words hold known data, so that
    // no search ever walks into a word that was never written.
    logic [DATA_W-1:0] plan_words [WORDS];
    bit                plan_known [WORDS];

    int beats_sent   = 0;
    bit src_idle     = 1'b0;
    bit sink_idle    = 1'b0;
    bit hold_request = 1'b0;

    bitmap_next_zero_search_top u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    bitmap_search_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_item   (out_item),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog. The slowest legal run has every search scan the whole map plus the longest
    // gaps and stalls; this is several times that.
    initial begin
        #(200_000_000);
        $display("bitmap_next_zero_search_top test failed");
        $finish;
    end

    // Walks the scan path of a search and returns the first word on it that was never
    // written, or -1 when the whole path is known.
    function automatic int unwritten_on_path(input logic [INDEX_W-1:0] start);
        int unsigned pos;
        int unsigned w;
        pos = int'(start) + 1;
        while (pos < MAP_BITS) begin
            w = pos / WORD_BITS;
            if (!plan_known[w[AW-1:0]]) begin
                return int'(w);
            end
            if ((~plan_words[w[AW-1:0]] >> (pos % WORD_BITS)) != '0) begin
                return -1;
            end
            pos = (w + 1) * WORD_BITS;
        end
        return -1;
    endfunction

    // Map contents lean toward dense words, as in an allocation map, so that searches
    // often skip several full words before they land.
    function automatic logic [DATA_W-1:0] dense_word();
        logic [DATA_W-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = '1;
            4, 5, 6: begin
                v = '1;
                v[BIT_W'($urandom_range(0, WORD_BITS - 1))] = 1'b0;
            end
            7, 8: v = {$urandom, $urandom};
            default: v = {$urandom, $urandom} & {$urandom, $urandom};
        endcase
        return v;
    endfunction

    // One beat on the input channel. An optional idle burst comes first; the payload
    // then holds until the block takes it.
    task automatic send_beat(input t_in_item it);
        if (src_idle && $urandom_range(0, 3) == 0) begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat ($urandom_range(0, 4)) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        beats_sent++;
    endtask

    // Write beat; the unused start index carries random junk.
    task automatic put_word(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        t_in_item it;
        it.kind        = KIND_WRITE;
        it.word_addr   = addr;
        it.word_data   = data;
        it.start_index = INDEX_W'($urandom_range(0, 65535));
        plan_words[addr] = data;
        plan_known[addr] = 1'b1;
        send_beat(it);
    endtask

    // Search beat. Any word on the path that is still unknown gets written first.
    task automatic find_after(input logic [INDEX_W-1:0] start);
        t_in_item it;
        int       hole;
        hole = unwritten_on_path(start);
        while (hole >= 0) begin
            put_word(ADDR_W'(hole), dense_word());
            hole = unwritten_on_path(start);
        end
        it.kind        = KIND_SEARCH;
        it.word_addr   = ADDR_W'($urandom_range(0, WORDS - 1));
        it.word_data   = {$urandom, $urandom};
        it.start_index = start;
        send_beat(it);
    endtask

    // Drops valid and waits until every search has had its answer.
    task automatic wait_all_answered();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
    endtask

    // Result side. Short random stall bursts, plus one long hold-off that lets the
    // output register and the search in flight back up into the input channel.
    initial begin : result_sink
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_request) begin
                hold_request = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                out_stall <= 1'b0;
            end else if (sink_idle && $urandom_range(0, 3) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial begin : stimulus
        logic [INDEX_W-1:0] start;
        logic [ADDR_W-1:0]  addr;
        int                 pick;
        int                 next_shuffle;
        bit                 drained;
        bit                 held;

        in_valid = 1'b0;
        in_item  = '0;
        rst_n    = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part. An empty first word gives the nearest possible hit, and the
        // top start index is the last bit of the map, so no word is scanned at all.
        put_word(ADDR_W'(0), '0);
        find_after(INDEX_W'(0));
        find_after(16'hFFFF);

        // The last two words full: the scan runs off the end of the map.
        put_word(ADDR_W'(WORDS - 2), '1);
        put_word(ADDR_W'(WORDS - 1), '1);
        find_after(INDEX_W'((WORDS - 2) * WORD_BITS - 1));

        // Only the very last bit of the map is free: the largest index that can be found,
        // reached from just before it and from the start of its word.
        put_word(ADDR_W'(WORDS - 1), {1'b0, {(DATA_W - 1){1'b1}}});
        find_after(INDEX_W'(MAP_BITS - 2));
        find_after(INDEX_W'((WORDS - 1) * WORD_BITS));

        // Two full words skipped before a hit at bit zero of the third.
        put_word(ADDR_W'(1), '1);
        put_word(ADDR_W'(2), '1);
        put_word(ADDR_W'(3), ~64'd1);
        find_after(INDEX_W'(WORD_BITS - 1));

        // A run of trailing ones from a start in mid-word.
        put_word(ADDR_W'(4), 64'h0000_FFFF_FFFF_FFFF);
        find_after(INDEX_W'(4 * WORD_BITS + 10));

        // Start on the top bit of a word: the answer lies in the next word.
        put_word(ADDR_W'(5), ~64'd1);
        find_after(INDEX_W'(4 * WORD_BITS + 63));

        // Alternating bits: the bit right after the start is taken, the next is free.
        put_word(ADDR_W'(6), 64'hAAAA_AAAA_AAAA_AAAA);
        find_after(INDEX_W'(6 * WORD_BITS));

        // Random part. Idling is reshuffled every hundred beats and switched off for the
        // tail of the run. Partway through, the sender pauses until all answers are in,
        // and later the sink holds off for a long stretch while beats keep coming.
        next_shuffle = 0;
        drained      = 1'b0;
        held         = 1'b0;
        while (beats_sent < ITEM_TARGET) begin
            if (beats_sent >= ITEM_TARGET - CALM_TAIL) begin
                src_idle  = 1'b0;
                sink_idle = 1'b0;
            end else if (beats_sent >= next_shuffle) begin
                src_idle     = ($urandom_range(0, 3) != 0);
                sink_idle    = ($urandom_range(0, 3) != 0);
                next_shuffle = next_shuffle + SHUFFLE_EVERY;
            end
            if (!drained && beats_sent >= DRAIN_AT) begin
                drained = 1'b1;
                wait_all_answered();
            end
            if (!held && beats_sent >= HOLD_AT) begin
                held         = 1'b1;
                hold_request = 1'b1;
            end

            pick = $urandom_range(0, 9);
            addr = ADDR_W'($urandom_range(0, WORDS - 1));
            if (pick < 3) begin
                put_word(addr, dense_word());
            end else if (pick == 3) begin
                put_word(addr, {$urandom, $urandom});
            end else begin
                case ($urandom_range(0, 9))
                    // Last or next-to-last bit of some word.
                    0, 1: start = INDEX_W'(addr * WORD_BITS + WORD_BITS - 1
                                           - $urandom_range(0, 1));
                    // Close to the end of the map, where not_found shows up.
                    2: start = INDEX_W'(MAP_BITS - 1 - $urandom_range(0, 3 * WORD_BITS));
                    3: start = INDEX_W'(MAP_BITS - 1 - $urandom_range(0, 1));
                    default: start = INDEX_W'($urandom_range(0, MAP_BITS - 1));
                endcase
                find_after(start);
            end
        end

        wait_all_answered();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("bitmap_next_zero_search_top test passed");
        end else begin
            $display("bitmap_next_zero_search_top test failed");
        end
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/bnz_pkg.sv
hw/rtl/bnz_useq.sv
hw/rtl/bnz_datapath.sv
hw/rtl/bitmap_next_zero_search_top.sv
tb/bitmap_search_checker.sv
tb/testbench.sv
